// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the sorter.
// Needs nothing else; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, with the check held off while reset is low.
`define CSS_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define CSS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

// File: rtl/css_pkg.sv
// Types and codes for the conveyor sort sequencer.
// No dependencies; used by every module of the block.
package css_pkg;

  typedef enum logic [2:0] {
    ST_OFF         = 3'd0,
    ST_IDLE        = 3'd1,
    ST_ENTERING    = 3'd2,
    ST_ON_BELT     = 3'd3,
    ST_AT_CAMERA   = 3'd4,
    ST_TILT_BOTTLE = 3'd5,
    ST_TILT_CAN    = 3'd6,
    ST_REJECTING   = 3'd7
  } stage_t;

  localparam logic [1:0] ARM_NONE   = 2'd0;
  localparam logic [1:0] ARM_ARM    = 2'd1;
  localparam logic [1:0] ARM_DISARM = 2'd2;

  localparam logic [1:0] VERD_NONE   = 2'd0;
  localparam logic [1:0] VERD_BOTTLE = 2'd1;
  localparam logic [1:0] VERD_CAN    = 2'd2;
  localparam logic [1:0] VERD_REJECT = 2'd3;

  localparam logic [1:0] CAUSE_NOT_RECYCLABLE = 2'd0;
  localparam logic [1:0] CAUSE_BOTTLE_BIN     = 2'd1;
  localparam logic [1:0] CAUSE_CAN_BIN        = 2'd2;

  localparam logic [1:0] BELT_HALT  = 2'd0;
  localparam logic [1:0] BELT_AHEAD = 2'd1;
  localparam logic [1:0] BELT_BACK  = 2'd2;

  localparam logic [3:0] EV_NONE           = 4'd0;
  localparam logic [3:0] EV_READY          = 4'd1;
  localparam logic [3:0] EV_ENTRY          = 4'd2;
  localparam logic [3:0] EV_REJ_NO_ROOM    = 4'd3;
  localparam logic [3:0] EV_BELT           = 4'd4;
  localparam logic [3:0] EV_CAMERA         = 4'd5;
  localparam logic [3:0] EV_ACC_BOTTLE     = 4'd6;
  localparam logic [3:0] EV_ACC_CAN        = 4'd7;
  localparam logic [3:0] EV_REJ_BOTTLE     = 4'd8;
  localparam logic [3:0] EV_REJ_CAN        = 4'd9;
  localparam logic [3:0] EV_REJ_NOT_RECYC  = 4'd10;
  localparam logic [3:0] EV_DROP_BOTTLE    = 4'd11;
  localparam logic [3:0] EV_DROP_CAN       = 4'd12;
  localparam logic [3:0] EV_DONE_BOTTLE    = 4'd13;
  localparam logic [3:0] EV_DONE_CAN       = 4'd14;
  localparam logic [3:0] EV_DONE_NOT_RECYC = 4'd15;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_CENTRE  = 2'd1;
  localparam logic [1:0] CFG_BOTTLE  = 2'd2;
  localparam logic [1:0] CFG_CAN     = 2'd3;

  localparam logic [31:0] TIMEOUT_RST = 32'd8000;
  localparam logic [7:0]  CENTRE_RST  = 8'd90;
  localparam logic [7:0]  BOTTLE_RST  = 8'd30;
  localparam logic [7:0]  CAN_RST     = 8'd150;

  typedef struct packed {
    logic [1:0]  arm_cmd;
    logic [1:0]  verdict_cmd;
    logic        bottle_bin_full;
    logic        can_bin_full;
    logic        entry_new;
    logic        entry_present;
    logic        belt_seen;
    logic        camera_seen;
    logic        bottle_drop_new;
    logic        can_drop_new;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [3:0] event_first;
    logic [3:0] event_second;
    logic [1:0] belt_drive;
    logic [7:0] servo_angle;
    logic       lamp_on;
    logic [2:0] stage_now;
  } out_word_t;

  typedef struct packed {
    logic [31:0] stage_timeout_ms;
    logic [7:0]  servo_centre_deg;
    logic [7:0]  servo_bottle_deg;
    logic [7:0]  servo_can_deg;
  } cfg_t;

endpackage

// File: rtl/conveyor_sort_sequencer.sv
// Top level of the conveyor sort sequencer: input register, poll step, result register.
// Depends on css_pkg, css_cfg and css_step.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | in_word  (in_word_t, one poll)
//   out_    | output    | out_valid/out_stall | out_word (out_word_t, one result)
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word per cycle while out_stall stays low; a word passes the input register and then
// the result register, where out_valid rises and the result can be taken.
// The poll step sits between the input register and the result register, so the
// whole stage update of one word is combinational between them.
// Synchronous active-low reset: sequencer goes to off, all but the payload registers to their defaults.
// out_stall holds the result register and, when both registers are full, raises in_stall.
module conveyor_sort_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  css_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output css_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import css_pkg::*;

  cfg_t      cfg;
  in_word_t  s1_word_r;
  logic      s1_valid_r, s1_valid_nxt;
  out_word_t res;
  out_word_t out_word_r;
  logic      out_valid_r, out_valid_nxt;
  logic      advance;
  logic      fire;
  logic      take;

  // Advance the input register whenever the result register is empty or being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  css_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Step the sequencer state only when the word moves into the result register.
  css_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .word  (s1_word_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take)         s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire)            out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (take) s1_word_r  <= in_word;
    if (fire) out_word_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
endmodule

// File: rtl/css_cfg.sv
// Configuration register file of the sorter: timeout and three flap angles.
// Depends on css_pkg.
module css_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output css_pkg::cfg_t cfg
);
  import css_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stage_timeout_ms <= TIMEOUT_RST;
      cfg_r.servo_centre_deg <= CENTRE_RST;
      cfg_r.servo_bottle_deg <= BOTTLE_RST;
      cfg_r.servo_can_deg    <= CAN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT: cfg_r.stage_timeout_ms <= cfg_data;
        CFG_CENTRE:  cfg_r.servo_centre_deg <= cfg_data[7:0];
        CFG_BOTTLE:  cfg_r.servo_bottle_deg <= cfg_data[7:0];
        CFG_CAN:     cfg_r.servo_can_deg    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/css_step.sv
// Poll step of the sorter: stage machine, sequencer state and the result of one poll.
// Depends on css_pkg; the result is combinational from the held state and the word.
module css_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  css_pkg::in_word_t  word,
  input  css_pkg::cfg_t      cfg,
  output css_pkg::out_word_t res
);
  import css_pkg::*;

  stage_t      stage_r, stage_nxt;
  logic [31:0] start_r, start_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  cause_r, cause_nxt;
  logic [1:0]  belt_r, belt_nxt;
  logic [7:0]  servo_r, servo_nxt;
  logic        lamp_r, lamp_nxt;
  logic        stage_load;
  logic [3:0]  ev_a, ev_b;
  logic [1:0]  pv;
  logic [31:0] elapsed;
  logic        tmo;
  logic        baskets_full;
  logic        entry_any;

  assign pv           = (word.verdict_cmd != VERD_NONE) ? word.verdict_cmd : pend_r;
  assign elapsed      = word.now_ms - start_r;
  assign tmo          = elapsed > cfg.stage_timeout_ms;
  assign baskets_full = word.bottle_bin_full & word.can_bin_full;
  assign entry_any    = word.entry_new | word.entry_present;
  assign start_nxt    = stage_load ? word.now_ms : start_r;

  // Next stage and whether the stage clock restarts.
  always_comb begin
    stage_nxt  = stage_r;
    stage_load = 1'b0;
    if (word.arm_cmd == ARM_ARM) begin
      stage_nxt  = ST_IDLE;
      stage_load = 1'b1;
    end else if (word.arm_cmd == ARM_DISARM) begin
      stage_nxt  = ST_OFF;
      stage_load = 1'b1;
    end else begin
      unique case (stage_r)
        ST_OFF: ;
        ST_IDLE: begin
          if (word.entry_new) begin
            stage_nxt  = baskets_full ? ST_REJECTING : ST_ENTERING;
            stage_load = 1'b1;
          end
        end
        ST_ENTERING: begin
          if (word.belt_seen) begin
            stage_nxt  = ST_ON_BELT;
            stage_load = 1'b1;
          end else if (tmo) begin
            stage_nxt  = ST_REJECTING;
            stage_load = 1'b1;
          end
        end
        ST_ON_BELT: begin
          if (word.camera_seen) begin
            stage_nxt  = ST_AT_CAMERA;
            stage_load = 1'b1;
          end else if (tmo) begin
            stage_nxt  = ST_REJECTING;
            stage_load = 1'b1;
          end
        end
        ST_AT_CAMERA: begin
          if (pv == VERD_BOTTLE) begin
            stage_nxt  = word.bottle_bin_full ? ST_REJECTING : ST_TILT_BOTTLE;
            stage_load = 1'b1;
          end else if (pv == VERD_CAN) begin
            stage_nxt  = word.can_bin_full ? ST_REJECTING : ST_TILT_CAN;
            stage_load = 1'b1;
          end else if (pv == VERD_REJECT) begin
            stage_nxt  = ST_REJECTING;
            stage_load = 1'b1;
          end
        end
        ST_TILT_BOTTLE: begin
          if (word.bottle_drop_new || tmo) begin
            stage_nxt  = ST_IDLE;
            stage_load = 1'b1;
          end
        end
        ST_TILT_CAN: begin
          if (word.can_drop_new || tmo) begin
            stage_nxt  = ST_IDLE;
            stage_load = 1'b1;
          end
        end
        ST_REJECTING: begin
          if (entry_any || tmo) begin
            stage_nxt  = ST_IDLE;
            stage_load = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Events, actuators, pending verdict and reject cause.
  always_comb begin
    ev_a      = EV_NONE;
    ev_b      = EV_NONE;
    pend_nxt  = pv;
    cause_nxt = cause_r;
    belt_nxt  = belt_r;
    servo_nxt = servo_r;
    lamp_nxt  = lamp_r;
    if (word.arm_cmd == ARM_ARM) begin
      servo_nxt = cfg.servo_centre_deg;
      belt_nxt  = BELT_HALT;
      pend_nxt  = VERD_NONE;
      ev_a      = EV_READY;
    end else if (word.arm_cmd == ARM_DISARM) begin
      belt_nxt  = BELT_HALT;
      lamp_nxt  = 1'b0;
      servo_nxt = cfg.servo_centre_deg;
    end else begin
      unique case (stage_r)
        ST_OFF: ;
        ST_IDLE: begin
          if (word.entry_new) begin
            ev_a     = EV_ENTRY;
            lamp_nxt = 1'b1;
            if (baskets_full) begin
              ev_b      = EV_REJ_NO_ROOM;
              cause_nxt = CAUSE_NOT_RECYCLABLE;
              belt_nxt  = BELT_BACK;
            end else begin
              belt_nxt = BELT_AHEAD;
            end
          end
        end
        ST_ENTERING: begin
          if (word.belt_seen) begin
            ev_a = EV_BELT;
          end else if (tmo) begin
            cause_nxt = CAUSE_NOT_RECYCLABLE;
            belt_nxt  = BELT_BACK;
          end
        end
        ST_ON_BELT: begin
          if (word.camera_seen) begin
            belt_nxt = BELT_HALT;
            pend_nxt = VERD_NONE;
            ev_a     = EV_CAMERA;
          end else if (tmo) begin
            cause_nxt = CAUSE_NOT_RECYCLABLE;
            belt_nxt  = BELT_BACK;
          end
        end
        ST_AT_CAMERA: begin
          if (pv == VERD_BOTTLE) begin
            pend_nxt = VERD_NONE;
            if (word.bottle_bin_full) begin
              ev_a      = EV_REJ_BOTTLE;
              cause_nxt = CAUSE_BOTTLE_BIN;
              belt_nxt  = BELT_BACK;
            end else begin
              ev_a      = EV_ACC_BOTTLE;
              servo_nxt = cfg.servo_bottle_deg;
              belt_nxt  = BELT_AHEAD;
            end
          end else if (pv == VERD_CAN) begin
            pend_nxt = VERD_NONE;
            if (word.can_bin_full) begin
              ev_a      = EV_REJ_CAN;
              cause_nxt = CAUSE_CAN_BIN;
              belt_nxt  = BELT_BACK;
            end else begin
              ev_a      = EV_ACC_CAN;
              servo_nxt = cfg.servo_can_deg;
              belt_nxt  = BELT_AHEAD;
            end
          end else if (pv == VERD_REJECT) begin
            pend_nxt  = VERD_NONE;
            ev_a      = EV_REJ_NOT_RECYC;
            cause_nxt = CAUSE_NOT_RECYCLABLE;
            belt_nxt  = BELT_BACK;
          end
        end
        ST_TILT_BOTTLE: begin
          if (word.bottle_drop_new || tmo) begin
            if (word.bottle_drop_new) ev_a = EV_DROP_BOTTLE;
            belt_nxt  = BELT_HALT;
            servo_nxt = cfg.servo_centre_deg;
          end
        end
        ST_TILT_CAN: begin
          if (word.can_drop_new || tmo) begin
            if (word.can_drop_new) ev_a = EV_DROP_CAN;
            belt_nxt  = BELT_HALT;
            servo_nxt = cfg.servo_centre_deg;
          end
        end
        ST_REJECTING: begin
          if (entry_any) begin
            belt_nxt  = BELT_HALT;
            servo_nxt = cfg.servo_centre_deg;
            case (cause_r)
              CAUSE_BOTTLE_BIN: ev_a = EV_DONE_BOTTLE;
              CAUSE_CAN_BIN:    ev_a = EV_DONE_CAN;
              default:          ev_a = EV_DONE_NOT_RECYC;
            endcase
          end else if (tmo) begin
            // timed-out reject keeps the flap where it is
            belt_nxt = BELT_HALT;
            ev_a     = EV_DONE_NOT_RECYC;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.event_first  = ev_a;
  assign res.event_second = ev_b;
  assign res.belt_drive   = belt_nxt;
  assign res.servo_angle  = servo_nxt;
  assign res.lamp_on      = lamp_nxt;
  assign res.stage_now    = stage_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_OFF;
      start_r <= '0;
      pend_r  <= VERD_NONE;
      cause_r <= CAUSE_NOT_RECYCLABLE;
      belt_r  <= BELT_HALT;
      servo_r <= CENTRE_RST;
      lamp_r  <= 1'b0;
    end else if (fire) begin
      stage_r <= stage_nxt;
      start_r <= start_nxt;
      pend_r  <= pend_nxt;
      cause_r <= cause_nxt;
      belt_r  <= belt_nxt;
      servo_r <= servo_nxt;
      lamp_r  <= lamp_nxt;
    end
  end
endmodule

// File: rtl/css_chk.sv
// Port-level checker for the conveyor sort sequencer, bound to the top level.
// Depends on css_pkg and assert_macros.svh.
`include "assert_macros.svh"

module css_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input css_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input css_pkg::out_word_t out_word,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [1:0]         cfg_index,
  input logic [31:0]        cfg_data
);
  import css_pkg::*;

  logic held;
  logic pair_seen;
  logic pair_ok;
  logic off_seen;
  logic off_ok;

  assign held      = out_valid && out_stall;
  assign pair_seen = out_valid && (out_word.event_second != EV_NONE);
  assign pair_ok   = (out_word.event_first == EV_ENTRY) &&
                     (out_word.event_second == EV_REJ_NO_ROOM) &&
                     (out_word.stage_now == ST_REJECTING);
  assign off_seen  = out_valid && (out_word.stage_now == ST_OFF);
  assign off_ok    = (out_word.belt_drive == BELT_HALT) && !out_word.lamp_on &&
                     (out_word.event_first == EV_NONE);

  // a stalled result stays valid and unchanged
  `CSS_ASSERT(a_out_hold, clk, rst_n, held |=> out_valid, "result dropped under stall")
  `CSS_ASSERT(a_out_stable, clk, rst_n, held |=> $stable(out_word), "stalled result changed")
  // with no result waiting, the input never stalls
  `CSS_ASSERT_ALWAYS(a_in_free, clk, !out_valid |-> !in_stall, "input stalled with empty output")
  // a second event only ever pairs an entry with a both-full reject
  `CSS_ASSERT(a_two_events, clk, rst_n, pair_seen |-> pair_ok, "bad event pair")
  // the off stage has the belt stopped, the lamp dark and no event
  `CSS_ASSERT(a_off_quiet, clk, rst_n, off_seen |-> off_ok, "off stage not quiet")
endmodule

bind conveyor_sort_sequencer css_chk u_css_chk (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for conveyor_sort_sequencer: directed polls, then random sorting runs.
// Depends on css_pkg and the RTL of the block; an in-file predictor supplies the expected words.
module testbench;
  import css_pkg::*;

  localparam int unsigned STUCK_LIMIT = 3000;  // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES = 200;   // long receiver hold-off that backs up the block
  localparam int unsigned PHASE_POLLS = 320;

  // Arm code with no meaning; the block treats it as no command.
  localparam logic [1:0] ARM_UNUSED = 2'd3;

  // Sensor bits in the order they sit in in_word_t, between verdict_cmd and now_ms.
  localparam logic [7:0] S_BFULL = 8'h80;
  localparam logic [7:0] S_CFULL = 8'h40;
  localparam logic [7:0] S_ENEW  = 8'h20;
  localparam logic [7:0] S_EPRES = 8'h10;
  localparam logic [7:0] S_BELT  = 8'h08;
  localparam logic [7:0] S_CAM   = 8'h04;
  localparam logic [7:0] S_BDROP = 8'h02;
  localparam logic [7:0] S_CDROP = 8'h01;

  typedef struct {
    in_word_t  poll;
    bit        typed;  // want holds a hand-written result
    out_word_t want;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  conveyor_sort_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the sequencer: settings plus the state one poll leaves behind.
  cfg_t        settings;
  stage_t      stg;
  logic [31:0] stg_start;
  logic [1:0]  verdict_held;
  logic [1:0]  cause;
  logic [1:0]  belt;
  logic [7:0]  servo;
  logic        lamp;

  out_word_t   predicted_outcomes[$];
  script_row_t directed[$];
  logic [31:0] clock_ms;   // millisecond clock the random polls walk along

  int unsigned mismatches = 0;
  int unsigned polls_sent = 0;
  int unsigned words_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned stuck_cycles = 0;
  logic [15:0] events_seen = '0;
  logic [7:0]  stages_seen = '0;

  // ---------------------------------------------------------------- predictor

  function automatic void enter_reject(logic [1:0] why, logic [31:0] now);
    cause     = why;
    belt      = BELT_BACK;
    stg       = ST_REJECTING;
    stg_start = now;
  endfunction

  function automatic void go_idle(logic [31:0] now);
    belt      = BELT_HALT;
    servo     = settings.servo_centre_deg;
    stg       = ST_IDLE;
    stg_start = now;
  endfunction

  // One poll: latch the verdict, then either the arm command or the stage step.
  function automatic out_word_t sort_step(in_word_t w);
    logic [3:0]  ev1;
    logic [3:0]  ev2;
    logic [31:0] elapsed;
    logic        late;
    out_word_t   r;
    ev1 = EV_NONE;
    ev2 = EV_NONE;
    // Wrapping difference; the stage start only moves after this check.
    elapsed = w.now_ms - stg_start;
    late = elapsed > settings.stage_timeout_ms;
    if (w.verdict_cmd != VERD_NONE) verdict_held = w.verdict_cmd;
    if (w.arm_cmd == ARM_ARM) begin
      servo        = settings.servo_centre_deg;
      belt         = BELT_HALT;
      verdict_held = VERD_NONE;
      stg          = ST_IDLE;
      stg_start    = w.now_ms;
      ev1          = EV_READY;
    end else if (w.arm_cmd == ARM_DISARM) begin
      belt      = BELT_HALT;
      lamp      = 1'b0;
      servo     = settings.servo_centre_deg;
      stg       = ST_OFF;
      stg_start = w.now_ms;
    end else begin
      case (stg)
        ST_IDLE: begin
          if (w.entry_new) begin
            ev1  = EV_ENTRY;
            lamp = 1'b1;
            if (w.bottle_bin_full && w.can_bin_full) begin
              ev2 = EV_REJ_NO_ROOM;
              enter_reject(CAUSE_NOT_RECYCLABLE, w.now_ms);
            end else begin
              belt      = BELT_AHEAD;
              stg       = ST_ENTERING;
              stg_start = w.now_ms;
            end
          end
        end
        ST_ENTERING: begin
          if (w.belt_seen) begin
            ev1       = EV_BELT;
            stg       = ST_ON_BELT;
            stg_start = w.now_ms;
          end else if (late) begin
            enter_reject(CAUSE_NOT_RECYCLABLE, w.now_ms);
          end
        end
        ST_ON_BELT: begin
          if (w.camera_seen) begin
            belt         = BELT_HALT;
            verdict_held = VERD_NONE;
            ev1          = EV_CAMERA;
            stg          = ST_AT_CAMERA;
            stg_start    = w.now_ms;
          end else if (late) begin
            enter_reject(CAUSE_NOT_RECYCLABLE, w.now_ms);
          end
        end
        ST_AT_CAMERA: begin
          if (verdict_held == VERD_BOTTLE) begin
            verdict_held = VERD_NONE;
            if (w.bottle_bin_full) begin
              ev1 = EV_REJ_BOTTLE;
              enter_reject(CAUSE_BOTTLE_BIN, w.now_ms);
            end else begin
              ev1       = EV_ACC_BOTTLE;
              servo     = settings.servo_bottle_deg;
              belt      = BELT_AHEAD;
              stg       = ST_TILT_BOTTLE;
              stg_start = w.now_ms;
            end
          end else if (verdict_held == VERD_CAN) begin
            verdict_held = VERD_NONE;
            if (w.can_bin_full) begin
              ev1 = EV_REJ_CAN;
              enter_reject(CAUSE_CAN_BIN, w.now_ms);
            end else begin
              ev1       = EV_ACC_CAN;
              servo     = settings.servo_can_deg;
              belt      = BELT_AHEAD;
              stg       = ST_TILT_CAN;
              stg_start = w.now_ms;
            end
          end else if (verdict_held == VERD_REJECT) begin
            verdict_held = VERD_NONE;
            ev1 = EV_REJ_NOT_RECYC;
            enter_reject(CAUSE_NOT_RECYCLABLE, w.now_ms);
          end
        end
        ST_TILT_BOTTLE: begin
          if (w.bottle_drop_new) begin
            ev1 = EV_DROP_BOTTLE;
            go_idle(w.now_ms);
          end else if (late) begin
            go_idle(w.now_ms);
          end
        end
        ST_TILT_CAN: begin
          if (w.can_drop_new) begin
            ev1 = EV_DROP_CAN;
            go_idle(w.now_ms);
          end else if (late) begin
            go_idle(w.now_ms);
          end
        end
        ST_REJECTING: begin
          if (w.entry_new || w.entry_present) begin
            go_idle(w.now_ms);
            case (cause)
              CAUSE_BOTTLE_BIN: ev1 = EV_DONE_BOTTLE;
              CAUSE_CAN_BIN:    ev1 = EV_DONE_CAN;
              default:          ev1 = EV_DONE_NOT_RECYC;
            endcase
          end else if (late) begin
            // Timed-out reject: stop the belt but leave the flap where it is.
            belt      = BELT_HALT;
            ev1       = EV_DONE_NOT_RECYC;
            stg       = ST_IDLE;
            stg_start = w.now_ms;
          end
        end
        default: begin
        end
      endcase
    end
    r.event_first  = ev1;
    r.event_second = ev2;
    r.belt_drive   = belt;
    r.servo_angle  = servo;
    r.lamp_on      = lamp;
    r.stage_now    = stg;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic script_row_t row_of(logic [1:0] arm, logic [1:0] verd,
                                         logic [7:0] sensors, logic [31:0] now,
                                         bit typed, out_word_t want);
    script_row_t t;
    t.poll  = {arm, verd, sensors, now};
    t.typed = typed;
    t.want  = want;
    return t;
  endfunction

  // Build the next random poll from the stage the shadow is in, so most polls
  // push the item further along; a tenth are plain noise.
  function automatic in_word_t next_poll();
    in_word_t    w;
    int          pick;
    logic [63:0] noise;
    w = '0;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      // Land on the timeout boundary: exactly at it, or one past.
      clock_ms = stg_start + settings.stage_timeout_ms + $urandom_range(0, 1);
    end else if (pick == 1) begin
      clock_ms = $urandom;
    end else if (pick >= 6) begin
      clock_ms = clock_ms + $urandom_range(1, 60);
    end
    if ($urandom_range(0, 9) == 0) begin
      noise = {$urandom, $urandom};
      w = noise[$bits(in_word_t)-1:0];
      return w;
    end
    w.now_ms = clock_ms;
    case (stg)
      ST_OFF:       w.arm_cmd = ($urandom_range(0, 3) == 0) ? ARM_NONE : ARM_ARM;
      ST_IDLE: begin
        w.entry_new       = $urandom_range(0, 3) != 0;
        w.bottle_bin_full = $urandom_range(0, 2) == 0;
        w.can_bin_full    = $urandom_range(0, 2) == 0;
      end
      ST_ENTERING:  w.belt_seen = 1'($urandom_range(0, 1));
      ST_ON_BELT:   w.camera_seen = 1'($urandom_range(0, 1));
      ST_AT_CAMERA: begin
        w.verdict_cmd     = 2'($urandom_range(0, 3));
        w.bottle_bin_full = $urandom_range(0, 2) == 0;
        w.can_bin_full    = $urandom_range(0, 2) == 0;
      end
      ST_TILT_BOTTLE: begin
        w.bottle_drop_new = $urandom_range(0, 2) == 0;
        w.can_drop_new    = $urandom_range(0, 3) == 0;
      end
      ST_TILT_CAN: begin
        w.can_drop_new    = $urandom_range(0, 2) == 0;
        w.bottle_drop_new = $urandom_range(0, 3) == 0;
      end
      default: begin
        w.entry_new     = $urandom_range(0, 3) == 0;
        w.entry_present = $urandom_range(0, 3) == 0;
      end
    endcase
    // Stray commands and early verdicts, so they land in every stage.
    if ($urandom_range(0, 24) == 0) w.arm_cmd = 2'($urandom_range(1, 3));
    if ($urandom_range(0, 11) == 0) w.verdict_cmd = 2'($urandom_range(1, 3));
    return w;
  endfunction

  // Offer one word after a random gap, hold it until taken, then log what it
  // should produce. Entered and left at a falling edge.
  task automatic send_word(in_word_t w, bit no_gap, bit typed, out_word_t want);
    int        gap;
    out_word_t pred;
    gap = (no_gap || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pred = sort_step(w);
    predicted_outcomes.push_back(typed ? want : pred);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TIMEOUT: settings.stage_timeout_ms = val;
      CFG_CENTRE:  settings.servo_centre_deg = val[7:0];
      CFG_BOTTLE:  settings.servo_bottle_deg = val[7:0];
      default:     settings.servo_can_deg    = val[7:0];
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drain the block, then rewrite all four registers while it sits idle.
  task automatic load_settings(logic [31:0] tmo, logic [7:0] centre,
                               logic [7:0] bottle, logic [7:0] can);
    in_valid = 1'b0;
    while (predicted_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_CENTRE, {24'd0, centre});
    write_reg(CFG_BOTTLE, {24'd0, bottle});
    write_reg(CFG_CAN, {24'd0, can});
  endtask

  // ---------------------------------------------------------------- checking

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      events_seen <= events_seen | (16'h1 << out_word.event_first)
                                 | (16'h1 << out_word.event_second);
      stages_seen <= stages_seen | (8'h1 << out_word.stage_now);
      if (predicted_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing expected: %h", $realtime, out_word);
      end else begin
        want = predicted_outcomes.pop_front();
        words_checked++;
        if (out_word !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch, expected %p, got %p",
                     $realtime, want, out_word);
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, STUCK_LIMIT);
      $display("testbench failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: stall a random number of cycles before each word, with quiet
  // stretches of no stall, and serve the long hold-off when the sender asks.
  initial begin
    int pause;
    int quiet_left;
    quiet_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet_left > 0) begin
        pause = 0;
        quiet_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        pause = 0;
        quiet_left = 30;
      end else begin
        pause = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
      end
      if (holds_done < hold_requests) begin
        holds_done++;
        pause = HOLD_CYCLES;
      end
      if (pause > 0) begin
        out_stall = 1'b1;
        repeat (pause) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------- main flow

  initial begin
    int k;
    int ph;
    bit pressure;
    bit burst;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TIMEOUT;
    cfg_data  = '0;

    settings.stage_timeout_ms = TIMEOUT_RST;
    settings.servo_centre_deg = CENTRE_RST;
    settings.servo_bottle_deg = BOTTLE_RST;
    settings.servo_can_deg    = CAN_RST;
    stg          = ST_OFF;
    stg_start    = '0;
    verdict_held = VERD_NONE;
    cause        = CAUSE_NOT_RECYCLABLE;
    belt         = BELT_HALT;
    servo        = CENTRE_RST;
    lamp         = 1'b0;

    // Directed script at reset settings. Hand-written results where obvious,
    // the predictor for the rest. The first reject crosses the 2^32 wrap.
    directed.push_back(row_of(ARM_UNUSED, VERD_NONE, 8'hFF, 32'h0, 1'b1,
      {EV_NONE, EV_NONE, BELT_HALT, CENTRE_RST, 1'b0, ST_OFF}));
    directed.push_back(row_of(ARM_ARM, VERD_NONE, 8'h00, 32'hFFFF_FF00, 1'b1,
      {EV_READY, EV_NONE, BELT_HALT, CENTRE_RST, 1'b0, ST_IDLE}));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_BFULL | S_CFULL | S_ENEW, 32'hFFFF_FF10,
      1'b1, {EV_ENTRY, EV_REJ_NO_ROOM, BELT_BACK, CENTRE_RST, 1'b1, ST_REJECTING}));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, 8'h00, 32'h0000_1E50, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, 8'h00, 32'h0000_1E51, 1'b1,
      {EV_DONE_NOT_RECYC, EV_NONE, BELT_HALT, CENTRE_RST, 1'b1, ST_IDLE}));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_ENEW | S_BFULL, 32'h2000, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_CAN, S_BELT, 32'h2010, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_CAM, 32'h2020, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, 8'h00, 32'h2030, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_BOTTLE, S_BFULL, 32'h2040, 1'b1,
      {EV_REJ_BOTTLE, EV_NONE, BELT_BACK, CENTRE_RST, 1'b1, ST_REJECTING}));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_ENEW, 32'h2050, 1'b1,
      {EV_DONE_BOTTLE, EV_NONE, BELT_HALT, CENTRE_RST, 1'b1, ST_IDLE}));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_ENEW, 32'h3000, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, 8'h00, 32'h4F41, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_EPRES, 32'h4F50, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_ENEW | S_CFULL, 32'h5000, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_BELT, 32'h5010, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_CAM, 32'h5020, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_REJECT, 8'h00, 32'h5030, 1'b1,
      {EV_REJ_NOT_RECYC, EV_NONE, BELT_BACK, CENTRE_RST, 1'b1, ST_REJECTING}));
    directed.push_back(row_of(ARM_DISARM, VERD_NONE, 8'hFF, 32'h5040, 1'b1,
      {EV_NONE, EV_NONE, BELT_HALT, CENTRE_RST, 1'b0, ST_OFF}));
    directed.push_back(row_of(ARM_ARM, VERD_BOTTLE, 8'h00, 32'h6000, 1'b1,
      {EV_READY, EV_NONE, BELT_HALT, CENTRE_RST, 1'b0, ST_IDLE}));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_ENEW, 32'h6010, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_BELT, 32'h6020, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_CAM, 32'h6030, 1'b0, '0));
    directed.push_back(row_of(ARM_NONE, VERD_CAN, 8'h00, 32'h6040, 1'b1,
      {EV_ACC_CAN, EV_NONE, BELT_AHEAD, CAN_RST, 1'b1, ST_TILT_CAN}));
    directed.push_back(row_of(ARM_NONE, VERD_NONE, S_CDROP | S_BDROP, 32'h6050, 1'b1,
      {EV_DROP_CAN, EV_NONE, BELT_HALT, CENTRE_RST, 1'b1, ST_IDLE}));

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_word(directed[i].poll, 1'b0, directed[i].typed, directed[i].want);

    // Random phases, each at its own settings: zero timeout and centre angle, then the
    // highest timeout, a random mix, and back to reset values under back-pressure.
    for (ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: load_settings(32'd0, 8'd0, 8'd180, 8'd255);
        2: load_settings(32'hFFFF_FFFF, 8'd180, 8'd0, 8'd255);
        3: load_settings($urandom_range(1, 300), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: load_settings(TIMEOUT_RST, CENTRE_RST, BOTTLE_RST, CAN_RST);
      endcase
      clock_ms = (ph == 2) ? 32'hFFFF_F000 : $urandom;
      pressure = (ph == 4);
      for (k = 0; k < PHASE_POLLS; k++) begin
        // Ask for the long hold-off and keep offering words back to back
        // so the block fills and stalls its input.
        if (pressure && k == 120) hold_requests++;
        burst = pressure && k >= 120 && k < 200;
        send_word(next_poll(), burst || (k % 90) < 20, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (predicted_outcomes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (predicted_outcomes.size() != 0) begin
      $display("%0d expected words never arrived", predicted_outcomes.size());
      mismatches += predicted_outcomes.size();
    end

    $display("ran %0d polls (%0d scripted) over 5 settings with %0d register writes, %0d words checked",
             polls_sent, directed.size(), cfg_writes, words_checked);
    $display("results showed %0d of 16 event codes and %0d of 8 stages",
             $countones(events_seen), $countones(stages_seen));
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
